@@ hdl/bfi_pkg.sv @@
// bfi_pkg: types, character codes and the control store of the brainfuck step core
// no dependencies; used by every module under hdl except bfi_ram
`default_nettype none

package bfi_pkg;

	// program characters
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	// request operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_UNBAL = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic       op;
		logic [7:0] prog_char;
		logic [7:0] in_byte;
	} bfi_in_t;

	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic [10:0] prog_counter;
		logic        halted;
		logic [1:0]  status;
	} bfi_out_t;

	// datapath actions, one per control word
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_ACCEPT,
		ACT_LOAD,
		ACT_EXEC,
		ACT_SF_INIT,
		ACT_SB_INIT,
		ACT_SF_TEST,
		ACT_SB_TEST,
		ACT_SF_CHECK,
		ACT_SB_CHECK,
		ACT_IP_SCAN,
		ACT_IP_INC,
		ACT_EMIT
	} bfi_act_t;

	// jump conditions
	typedef enum logic [3:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_CLR_MORE,
		CND_NO_REQ,
		CND_IS_LOAD,
		CND_JMP_FWD,
		CND_JMP_BWD,
		CND_SF_END,
		CND_SB_END,
		CND_F_MISS,
		CND_B_MISS,
		CND_OUT_FREE
	} bfi_cond_t;

	localparam int UPC_W = 5;

	typedef struct packed {
		bfi_act_t         act;
		bfi_cond_t        cond;
		logic [UPC_W-1:0] target;
	} bfi_ctl_t;

	typedef struct packed {
		logic clr_more;
		logic no_req;
		logic is_load;
		logic jmp_fwd;
		logic jmp_bwd;
		logic sf_end;
		logic sb_end;
		logic f_miss;
		logic b_miss;
		logic out_free;
	} bfi_flags_t;

	// microprogram addresses
	localparam logic [UPC_W-1:0] U_CLEAR    = 5'd0;
	localparam logic [UPC_W-1:0] U_IDLE     = 5'd1;
	localparam logic [UPC_W-1:0] U_DECODE   = 5'd2;
	localparam logic [UPC_W-1:0] U_EXEC     = 5'd3;
	localparam logic [UPC_W-1:0] U_BWD      = 5'd4;
	localparam logic [UPC_W-1:0] U_RESULT   = 5'd5;
	localparam logic [UPC_W-1:0] U_HOLD     = 5'd6;
	localparam logic [UPC_W-1:0] U_SF_INIT  = 5'd7;
	localparam logic [UPC_W-1:0] U_SF_TEST  = 5'd8;
	localparam logic [UPC_W-1:0] U_SF_CHECK = 5'd9;
	localparam logic [UPC_W-1:0] U_SF_FOUND = 5'd10;
	localparam logic [UPC_W-1:0] U_SB_INIT  = 5'd11;
	localparam logic [UPC_W-1:0] U_SB_TEST  = 5'd12;
	localparam logic [UPC_W-1:0] U_SB_CHECK = 5'd13;
	localparam logic [UPC_W-1:0] U_SB_FOUND = 5'd14;
	localparam logic [UPC_W-1:0] U_IP_INC   = 5'd15;
	localparam logic [UPC_W-1:0] U_LOAD     = 5'd16;

	function automatic bfi_ctl_t bfi_rom(input logic [UPC_W-1:0] a);
		bfi_ctl_t w;
		case (a)
			U_CLEAR:    w = '{ACT_CLEAR,    CND_CLR_MORE, U_CLEAR};
			U_IDLE:     w = '{ACT_ACCEPT,   CND_NO_REQ,   U_IDLE};
			U_DECODE:   w = '{ACT_NONE,     CND_IS_LOAD,  U_LOAD};
			U_EXEC:     w = '{ACT_EXEC,     CND_JMP_FWD,  U_SF_INIT};
			U_BWD:      w = '{ACT_NONE,     CND_JMP_BWD,  U_SB_INIT};
			U_RESULT:   w = '{ACT_EMIT,     CND_OUT_FREE, U_IDLE};
			U_HOLD:     w = '{ACT_NONE,     CND_ALWAYS,   U_RESULT};
			U_SF_INIT:  w = '{ACT_SF_INIT,  CND_NEVER,    U_IDLE};
			U_SF_TEST:  w = '{ACT_SF_TEST,  CND_SF_END,   U_IP_INC};
			U_SF_CHECK: w = '{ACT_SF_CHECK, CND_F_MISS,   U_SF_TEST};
			U_SF_FOUND: w = '{ACT_IP_SCAN,  CND_ALWAYS,   U_RESULT};
			U_SB_INIT:  w = '{ACT_SB_INIT,  CND_NEVER,    U_IDLE};
			U_SB_TEST:  w = '{ACT_SB_TEST,  CND_SB_END,   U_IP_INC};
			U_SB_CHECK: w = '{ACT_SB_CHECK, CND_B_MISS,   U_SB_TEST};
			U_SB_FOUND: w = '{ACT_IP_SCAN,  CND_ALWAYS,   U_RESULT};
			U_IP_INC:   w = '{ACT_IP_INC,   CND_ALWAYS,   U_RESULT};
			U_LOAD:     w = '{ACT_LOAD,     CND_ALWAYS,   U_RESULT};
			default:    w = '{ACT_NONE,     CND_ALWAYS,   U_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ hdl/bfi_ram.sv @@
// bfi_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module bfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/bfi_sequencer.sv @@
// bfi_sequencer: micro program counter, control store and jump condition select
// depends on bfi_pkg
`default_nettype none

module bfi_sequencer (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire bfi_pkg::bfi_flags_t flags,
	output bfi_pkg::bfi_ctl_t        ctl
);
	import bfi_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_d;
	logic             take;

	assign ctl = bfi_rom(upc_q);

	always_comb begin
		case (ctl.cond)
			CND_NEVER:    take = 1'b0;
			CND_ALWAYS:   take = 1'b1;
			CND_CLR_MORE: take = flags.clr_more;
			CND_NO_REQ:   take = flags.no_req;
			CND_IS_LOAD:  take = flags.is_load;
			CND_JMP_FWD:  take = flags.jmp_fwd;
			CND_JMP_BWD:  take = flags.jmp_bwd;
			CND_SF_END:   take = flags.sf_end;
			CND_SB_END:   take = flags.sb_end;
			CND_F_MISS:   take = flags.f_miss;
			CND_B_MISS:   take = flags.b_miss;
			CND_OUT_FREE: take = flags.out_free;
			default:      take = 1'b0;
		endcase
		upc_d = take ? ctl.target : upc_q + UPC_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_CLEAR;
		end else begin
			upc_q <= upc_d;
		end
	end

	// the clear sweep is only ever entered from reset
	a_no_reenter_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q != U_CLEAR) |=> (upc_q != U_CLEAR))
		else $error("sequencer returned to the clear sweep");

endmodule

`default_nettype wire

@@ hdl/bfi_datapath.sv @@
// bfi_datapath: pointers, bracket balance, scan counters, program and tape memories,
// result register; driven by the sequencer control word. depends on bfi_pkg, bfi_ram
`default_nettype none

module bfi_datapath #(
	parameter int PROGRAM_DEPTH = 1024,
	parameter int TAPE_CELLS    = 1024
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire bfi_pkg::bfi_ctl_t   ctl,
	output bfi_pkg::bfi_flags_t      flags,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire bfi_pkg::bfi_in_t    in_data,
	output logic                     res_valid,
	input  wire                      res_ready,
	output bfi_pkg::bfi_out_t        res_data
);
	import bfi_pkg::*;

	localparam int IP_W  = $clog2(PROGRAM_DEPTH + 1);
	localparam int PA_W  = $clog2(PROGRAM_DEPTH);
	localparam int TA_W  = $clog2(TAPE_CELLS);
	localparam int BAL_W = IP_W + 1;

	bfi_in_t                  in_q;
	logic [IP_W-1:0]          len_q;
	logic [IP_W-1:0]          ip_q;
	logic [TA_W-1:0]          dp_q;
	logic signed [BAL_W-1:0]  bal_q;
	logic [TA_W-1:0]          clr_q;
	logic [IP_W-1:0]          scan_q;
	logic [IP_W-1:0]          depth_q;
	logic                     dot_q;
	logic [7:0]               byte_q;
	logic [1:0]               status_q;
	logic                     res_valid_q;
	bfi_out_t                 res_q;

	logic [7:0]      instr;
	logic [7:0]      cur_cell;
	logic            fire;
	logic            blocked;
	logic            full;
	logic            jump;
	logic [IP_W-1:0] scan_m1;
	logic [TA_W-1:0] dp_inc;
	logic [TA_W-1:0] dp_dec;
	logic            prog_we;
	logic            prog_re;
	logic [PA_W-1:0] prog_raddr;
	logic            tape_we;
	logic [TA_W-1:0] tape_waddr;
	logic [7:0]      tape_wdata;
	logic [IP_W+10:0] ip_wide;
	bfi_out_t        result;

	assign in_ready = (ctl.act == ACT_ACCEPT);
	assign fire     = in_valid && in_ready;
	assign blocked  = (bal_q != '0) || (ip_q >= len_q);
	assign full     = (len_q == IP_W'(PROGRAM_DEPTH));
	assign scan_m1  = scan_q - IP_W'(1);
	assign dp_inc   = (dp_q == TA_W'(TAPE_CELLS - 1)) ? '0 : dp_q + TA_W'(1);
	assign dp_dec   = (dp_q == '0) ? TA_W'(TAPE_CELLS - 1) : dp_q - TA_W'(1);

	assign flags.clr_more = (clr_q != TA_W'(TAPE_CELLS - 1));
	assign flags.no_req   = !in_valid;
	assign flags.is_load  = (in_q.op == OP_LOAD);
	assign flags.jmp_fwd  = !blocked && (instr == CH_OPEN) && (cur_cell == 8'd0);
	assign flags.jmp_bwd  = !blocked && (instr == CH_CLOSE) && (cur_cell != 8'd0);
	assign flags.sf_end   = (scan_q >= len_q);
	assign flags.sb_end   = (scan_q == '0);
	assign flags.f_miss   = !((instr == CH_CLOSE) && (depth_q == '0));
	assign flags.b_miss   = !((instr == CH_OPEN) && (depth_q == '0));
	assign flags.out_free = !res_valid_q || res_ready;
	assign jump           = flags.jmp_fwd || flags.jmp_bwd;

	// program store: appended at len, read at ip on accept and at the scan index (minus one when scanning backward)
	assign prog_we = (ctl.act == ACT_LOAD) && !full;
	assign prog_re = fire || (ctl.act == ACT_SF_TEST) || (ctl.act == ACT_SB_TEST);

	always_comb begin
		case (ctl.act)
			ACT_SF_TEST: prog_raddr = scan_q[PA_W-1:0];
			ACT_SB_TEST: prog_raddr = scan_m1[PA_W-1:0];
			default:     prog_raddr = ip_q[PA_W-1:0];
		endcase
	end

	bfi_ram #(
		.WIDTH (8),
		.DEPTH (PROGRAM_DEPTH)
	) u_prog (
		.clk   (clk),
		.we    (prog_we),
		.waddr (len_q[PA_W-1:0]),
		.wdata (in_q.prog_char),
		.re    (prog_re),
		.raddr (prog_raddr),
		.rdata (instr)
	);

	// tape: cleared after reset, then written by the cell-changing instructions
	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = dp_q;
		tape_wdata = cur_cell;
		if (ctl.act == ACT_CLEAR) begin
			tape_we    = 1'b1;
			tape_waddr = clr_q;
			tape_wdata = 8'd0;
		end else if (ctl.act == ACT_EXEC && !blocked) begin
			case (instr)
				CH_DEC: begin
					tape_we    = 1'b1;
					tape_wdata = cur_cell - 8'd1;
				end
				CH_INC: begin
					tape_we    = 1'b1;
					tape_wdata = cur_cell + 8'd1;
				end
				CH_IN: begin
					tape_we    = 1'b1;
					tape_wdata = in_q.in_byte;
				end
				default: tape_we = 1'b0;
			endcase
		end
	end

	bfi_ram #(
		.WIDTH (8),
		.DEPTH (TAPE_CELLS)
	) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (fire),
		.raddr (dp_q),
		.rdata (cur_cell)
	);

	// machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ip_q  <= '0;
			dp_q  <= '0;
			bal_q <= '0;
			clr_q <= '0;
		end else begin
			case (ctl.act)
				ACT_CLEAR: clr_q <= clr_q + TA_W'(1);
				ACT_LOAD: begin
					if (!full) begin
						len_q <= len_q + IP_W'(1);
						if (in_q.prog_char == CH_OPEN) begin
							bal_q <= bal_q + BAL_W'(1);
						end else if (in_q.prog_char == CH_CLOSE) begin
							bal_q <= bal_q - BAL_W'(1);
						end
					end
				end
				ACT_EXEC: begin
					if (!blocked) begin
						if (instr == CH_LEFT) begin
							dp_q <= dp_dec;
						end else if (instr == CH_RIGHT) begin
							dp_q <= dp_inc;
						end
						if (!jump) begin
							ip_q <= ip_q + IP_W'(1);
						end
					end
				end
				ACT_IP_SCAN: ip_q <= scan_q;
				ACT_IP_INC:  ip_q <= ip_q + IP_W'(1);
				default: ;
			endcase
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (ctl.act)
			ACT_ACCEPT: begin
				if (fire) begin
					in_q     <= in_data;
					dot_q    <= 1'b0;
					byte_q   <= 8'd0;
					status_q <= STATUS_OK;
				end
			end
			ACT_LOAD: begin
				if (full) begin
					status_q <= STATUS_FULL;
				end
			end
			ACT_EXEC: begin
				if (bal_q != '0) begin
					status_q <= STATUS_UNBAL;
				end else if (!blocked && instr == CH_OUT) begin
					dot_q  <= 1'b1;
					byte_q <= cur_cell;
				end
			end
			ACT_SF_INIT: begin
				scan_q  <= ip_q + IP_W'(1);
				depth_q <= '0;
			end
			ACT_SB_INIT: begin
				scan_q  <= ip_q;
				depth_q <= '0;
			end
			ACT_SF_CHECK: begin
				// scan index ends one past the match
				scan_q <= scan_q + IP_W'(1);
				if (instr == CH_OPEN) begin
					depth_q <= depth_q + IP_W'(1);
				end else if (instr == CH_CLOSE && depth_q != '0) begin
					depth_q <= depth_q - IP_W'(1);
				end
			end
			ACT_SB_CHECK: begin
				// scan index holds one past the entry just read
				if (flags.b_miss) begin
					scan_q <= scan_m1;
				end
				if (instr == CH_CLOSE) begin
					depth_q <= depth_q + IP_W'(1);
				end else if (instr == CH_OPEN && depth_q != '0) begin
					depth_q <= depth_q - IP_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign ip_wide = {11'd0, ip_q};

	always_comb begin
		result.out_valid    = dot_q;
		result.out_byte     = byte_q;
		result.prog_counter = ip_wide[10:0];
		result.halted       = (ip_q >= len_q);
		result.status       = status_q;
	end

	// result register; the next request may be taken while it waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.act == ACT_EMIT && flags.out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act == ACT_EMIT && flags.out_free) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= IP_W'(PROGRAM_DEPTH))
		else $error("program length beyond store depth");

	a_ip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ip_q <= len_q)
		else $error("instruction pointer beyond program length");

	a_dp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_q <= TA_W'(TAPE_CELLS - 1))
		else $error("data pointer off the tape");

	a_exec_write: assert property (@(posedge clk) disable iff (!arst_n)
		(tape_we && ctl.act != ACT_CLEAR) |-> (bal_q == '0 && ip_q < len_q))
		else $error("tape written by a blocked step");

endmodule

`default_nettype wire

@@ hdl/brainfuck_interpreter_step_core.sv @@
// brainfuck_interpreter_step_core: top level of the microcoded brainfuck machine
// depends on bfi_pkg, bfi_sequencer, bfi_datapath (and bfi_ram through it)
//
// Requests enter on in_valid/in_ready/in_data; op 0 appends prog_char to the
// program store and tracks the bracket balance, op 1 executes one instruction
// at the instruction pointer (in_byte feeds ','). Each request gives exactly one
// result on res_valid/res_ready/res_data.
// After reset the sequencer sweeps the tape to zero, one cell per cycle;
// in_ready stays low until the sweep is done.
// A load request passes the decode and load steps on its way to the result
// register, a step request the exec step and, unless it jumps forward, the
// backward-jump test; a taken bracket jump then scans the program in test and
// check steps (one control-store step issues the program read, the next checks
// the byte), and when no partner is found the instruction pointer is stepped
// past the bracket. One request is in work at a time; a new request is accepted
// only after the previous one has been written to the result register.
// A finished result waits in the output register while the next request is
// accepted and worked on; the sequencer holds before writing a further result
// until the receiver has taken the previous one.
`default_nettype none

module brainfuck_interpreter_step_core #(
	parameter int PROGRAM_DEPTH = 1024,
	parameter int TAPE_CELLS    = 1024
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire bfi_pkg::bfi_in_t  in_data,
	output logic                   res_valid,
	input  wire                    res_ready,
	output bfi_pkg::bfi_out_t      res_data
);
	import bfi_pkg::*;

	bfi_ctl_t   ctl;
	bfi_flags_t flags;

	bfi_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	bfi_datapath #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.TAPE_CELLS    (TAPE_CELLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.flags     (flags),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire
